### hw/rtl/sgct_pkg.sv
// Shared types and constants for the stick-gesture calibration trigger.
// Used by sgct_pose, sgct_step and the top level; depends on nothing else.
package sgct_pkg;

    localparam int CH_W       = 11;
    localparam int THRESH_W   = 10;
    localparam int HOLD_W     = 16;
    localparam int TICK_W     = 32;
    localparam int BEEP_W     = 16;
    localparam int TEMP_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    // added to the mcu temperature for the heater target
    localparam logic signed [TEMP_W:0] HEAT_OFFSET = 9'sd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_MS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_CYCLE_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_PAUSE_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEAT_TEMP    = 3'd6;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_UPPER = 2'd2,
        MODE_LOWER = 2'd3
    } mode_t;

    typedef struct packed {
        logic [THRESH_W-1:0]      stick_threshold;
        logic [HOLD_W-1:0]        hold_ticks;
        logic [TICK_W-1:0]        window_ms;
        logic [TICK_W-1:0]        middle_ms;
        logic [BEEP_W-1:0]        beep_cycle_ticks;
        logic [BEEP_W-1:0]        beep_pause_ticks;
        logic signed [TEMP_W-1:0] max_heat_temp;
    } cfg_t;

    // input word, first field in the lowest bits
    typedef struct packed {
        logic [1:0]               pad;
        logic [TICK_W-1:0]        now_tick;
        logic signed [TEMP_W-1:0] mcu_temp;
        logic                     right_switch_down;
        logic                     left_switch_down;
        logic signed [CH_W-1:0]   stick_ch3;
        logic signed [CH_W-1:0]   stick_ch2;
        logic signed [CH_W-1:0]   stick_ch1;
        logic signed [CH_W-1:0]   stick_ch0;
    } in_item_t;

    // result word, first field in the lowest bits
    typedef struct packed {
        logic [2:0]               pad;
        mode_t                    mode;
        logic                     beep_stop;
        logic                     beep_start;
        logic signed [TEMP_W-1:0] heat_target;
        logic                     gyro_cal_start;
    } out_item_t;

    // pose flags, switches already folded in
    typedef struct packed {
        logic inner;
        logic upper;
        logic lower;
    } pose_t;

endpackage

### hw/rtl/sgct_pose.sv
// Stick pose classifier: compares the four channels against the threshold.
// Depends on sgct_pkg.
module sgct_pose (
    input  sgct_pkg::in_item_t              item,
    input  logic [sgct_pkg::THRESH_W-1:0]   stick_threshold,
    output sgct_pkg::pose_t                 pose
);
    import sgct_pkg::*;

    logic signed [CH_W:0] pos_th;
    logic signed [CH_W:0] neg_th;
    logic [3:0]           hi;
    logic [3:0]           lo;
    logic                 both_down;

    // threshold as signed bounds one bit wider than a channel
    assign pos_th = $signed({{(CH_W + 1 - THRESH_W){1'b0}}, stick_threshold});
    assign neg_th = -pos_th;

    // per-channel extreme tests
    always_comb
    begin
        hi[0] = $signed({item.stick_ch0[CH_W-1], item.stick_ch0}) > pos_th;
        hi[1] = $signed({item.stick_ch1[CH_W-1], item.stick_ch1}) > pos_th;
        hi[2] = $signed({item.stick_ch2[CH_W-1], item.stick_ch2}) > pos_th;
        hi[3] = $signed({item.stick_ch3[CH_W-1], item.stick_ch3}) > pos_th;
        lo[0] = $signed({item.stick_ch0[CH_W-1], item.stick_ch0}) < neg_th;
        lo[1] = $signed({item.stick_ch1[CH_W-1], item.stick_ch1}) < neg_th;
        lo[2] = $signed({item.stick_ch2[CH_W-1], item.stick_ch2}) < neg_th;
        lo[3] = $signed({item.stick_ch3[CH_W-1], item.stick_ch3}) < neg_th;
    end

    assign both_down = item.left_switch_down & item.right_switch_down;

    // inner eight, upper outer eight, lower outer eight
    assign pose.inner = both_down & lo[0] & lo[1] & hi[2] & lo[3];
    assign pose.upper = both_down & hi[0] & hi[1] & lo[2] & hi[3];
    assign pose.lower = both_down & hi[0] & lo[1] & lo[2] & lo[3];

endmodule

### hw/rtl/sgct_step.sv
// Gesture state and one-word step logic: hold count, mode, window, beep cadence.
// Depends on sgct_pkg; takes pose flags from sgct_pose.
module sgct_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  sgct_pkg::in_item_t item,
    input  sgct_pkg::pose_t    pose,
    input  sgct_pkg::cfg_t     cfg,
    output sgct_pkg::out_item_t result
);
    import sgct_pkg::*;

    logic [HOLD_W-1:0]        hold_count_reg,   hold_count_next;
    mode_t                    mode_reg,         mode_next;
    logic [TICK_W-1:0]        window_start_reg, window_start_next;
    logic [BEEP_W-1:0]        beep_count_reg,   beep_count_next;
    logic signed [TEMP_W-1:0] heat_target_reg,  heat_target_next;

    logic                     over;
    mode_t                    mode_act;
    logic signed [TEMP_W:0]   heat_sum;
    logic signed [TEMP_W:0]   heat_max;
    logic [TICK_W-1:0]        elapsed;
    logic                     timed_out;
    logic                     cal;
    logic                     bstart;
    logic                     bstop;
    logic [BEEP_W-1:0]        beep_inc;

    assign over     = hold_count_reg > cfg.hold_ticks;
    assign heat_sum = $signed({item.mcu_temp[TEMP_W-1], item.mcu_temp}) + HEAT_OFFSET;
    assign heat_max = $signed({cfg.max_heat_temp[TEMP_W-1], cfg.max_heat_temp});
    assign beep_inc = beep_count_reg + 1'b1;

    always_comb
    begin
        hold_count_next   = hold_count_reg;
        mode_act          = mode_reg;
        window_start_next = window_start_reg;
        heat_target_next  = heat_target_reg;
        beep_count_next   = beep_count_reg;
        cal               = 1'b0;
        bstart            = 1'b0;
        bstop             = 1'b0;

        // act on the hold count left by the previous word
        if (over)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    window_start_next = item.now_tick;
                    mode_act          = MODE_OPEN;
                    hold_count_next   = '0;
                end
                MODE_UPPER:
                begin
                    mode_act        = MODE_IDLE;
                    hold_count_next = '0;
                end
                MODE_LOWER:
                begin
                    mode_act        = MODE_IDLE;
                    hold_count_next = '0;
                    cal             = 1'b1;
                    if (heat_sum > heat_max)
                        heat_target_next = heat_max[TEMP_W-1:0];
                    else
                        heat_target_next = heat_sum[TEMP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        // classify the current pose
        mode_next = mode_act;
        if (pose.inner && mode_act == MODE_IDLE)
            hold_count_next = hold_count_next + 1'b1;
        else if (pose.upper && mode_act != MODE_IDLE)
        begin
            hold_count_next = hold_count_next + 1'b1;
            mode_next       = MODE_UPPER;
        end
        else if (pose.lower && mode_act != MODE_IDLE)
        begin
            hold_count_next = hold_count_next + 1'b1;
            mode_next       = MODE_LOWER;
        end
        else
            hold_count_next = '0;

        // window timeout and start beep
        elapsed   = item.now_tick - window_start_next;
        timed_out = elapsed > cfg.window_ms;
        if (timed_out)
            mode_next = MODE_IDLE;
        else if (elapsed <= cfg.middle_ms && elapsed != '0 && mode_next != MODE_IDLE)
            bstart = 1'b1;

        // intermittent beep cadence
        if (!timed_out && mode_next != MODE_IDLE)
        begin
            beep_count_next = beep_inc;
            if (beep_inc > cfg.beep_cycle_ticks)
                beep_count_next = '0;
            bstop = beep_count_next > cfg.beep_pause_ticks;
        end
    end

    // state updates once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg   <= '0;
            mode_reg         <= MODE_IDLE;
            window_start_reg <= '0;
            beep_count_reg   <= '0;
            heat_target_reg  <= '0;
        end
        else if (fire)
        begin
            hold_count_reg   <= hold_count_next;
            mode_reg         <= mode_next;
            window_start_reg <= window_start_next;
            beep_count_reg   <= beep_count_next;
            heat_target_reg  <= heat_target_next;
        end
    end

    // result word
    always_comb
    begin
        result                = '0;
        result.gyro_cal_start = cal;
        result.heat_target    = heat_target_next;
        result.beep_start     = bstart;
        result.beep_stop      = bstop;
        result.mode           = mode_next;
    end

endmodule

### hw/rtl/stick_gesture_calibration_trigger.sv
// Stick-gesture calibration trigger top level: config registers, input and
// result registers, stream handshake. Depends on sgct_pkg, sgct_pose, sgct_step.
// The result word is registered: input register, step logic, result register.
// Throughput: one word per cycle while m_tready does not stall the result register, set by the
// step logic, which forms each result combinationally between the input and result registers.
// Reset: rst_n async active low clears state and valid flags and loads
// the default configuration.
module stick_gesture_calibration_trigger (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_wen,
    input  logic [sgct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // stick_ch0, stick_ch1, stick_ch2, stick_ch3, left_switch_down,
    // right_switch_down, mcu_temp, now_tick, 2 bits zero
    input  logic [sgct_pkg::IN_DATA_W-1:0]     s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // gyro_cal_start, heat_target, beep_start, beep_stop, mode, 3 bits zero
    output logic [sgct_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import sgct_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      fire;
    pose_t     pose;
    out_item_t result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_threshold  <= 10'd600;
            cfg_reg.hold_ticks       <= 16'd2000;
            cfg_reg.window_ms        <= 32'd20000;
            cfg_reg.middle_ms        <= 32'd10000;
            cfg_reg.beep_cycle_ticks <= 16'd400;
            cfg_reg.beep_pause_ticks <= 16'd200;
            cfg_reg.max_heat_temp    <= 8'sd45;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_STICK_THRESHOLD:  cfg_reg.stick_threshold  <= cfg_wdata[THRESH_W-1:0];
                CFG_HOLD_TICKS:       cfg_reg.hold_ticks       <= cfg_wdata[HOLD_W-1:0];
                CFG_WINDOW_MS:        cfg_reg.window_ms        <= cfg_wdata[TICK_W-1:0];
                CFG_MIDDLE_MS:        cfg_reg.middle_ms        <= cfg_wdata[TICK_W-1:0];
                CFG_BEEP_CYCLE_TICKS: cfg_reg.beep_cycle_ticks <= cfg_wdata[BEEP_W-1:0];
                CFG_BEEP_PAUSE_TICKS: cfg_reg.beep_pause_ticks <= cfg_wdata[BEEP_W-1:0];
                CFG_MAX_HEAT_TEMP:    cfg_reg.max_heat_temp    <= $signed(cfg_wdata[TEMP_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // handshake: the input register moves on whenever the result register frees
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= in_item_t'(s_tdata);
    end

    sgct_pose u_pose (
        .item            (in_item_reg),
        .stick_threshold (cfg_reg.stick_threshold),
        .pose            (pose)
    );

    sgct_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .pose   (pose),
        .cfg    (cfg_reg),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_item_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    // a calibration request always leaves the mode idle
    a_cal_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[12:11] == MODE_IDLE)
        else $error("calibration word with mode not idle");

    // beeps only while a window is open
    a_beep_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[9] || m_tdata[10]) |-> m_tdata[12:11] != MODE_IDLE)
        else $error("beep issued with mode idle");

    // input side stalls only behind a stalled result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a word in the input register reaches the result register next cycle
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed word lost");

endmodule
